// ===== rtl/core/bdrc_pkg.sv =====
`timescale 1ns / 1ps

package bdrc_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int CNT_W       = OFFSET_BITS + 1;
  localparam int POS_W       = 32;
  localparam int LEN_W       = 33;
  localparam int TOT_W       = 33;
  localparam int SIM_W       = 15;
  localparam int NUM_W       = CNT_W + SIM_W;
  localparam int STEP_W      = $clog2(SIM_W);

  localparam logic [SIM_W-1:0] SIM_FULL = SIM_W'(25600);

  typedef enum logic [1:0] {
    KIND_MATCH,
    KIND_MISMATCH,
    KIND_DELETE,
    KIND_INSERT
  } kind_e;

  typedef enum logic [1:0] {
    REC_ENTRY,
    REC_BLOCK,
    REC_SUMMARY
  } rec_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_ENTRY,
    ST_FLUSH,
    ST_DIV_START,
    ST_DIV,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic [7:0] byte_a;
    logic       has_a;
    logic [7:0] byte_b;
    logic       has_b;
    logic       end_of_compare;
  } in_t;

  typedef struct packed {
    rec_e              record_type;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  run_length;
    kind_e             diff_kind;
    logic [7:0]        out_byte_a;
    logic [7:0]        out_byte_b;
    logic [TOT_W-1:0]  match_total;
    logic [TOT_W-1:0]  mismatch_total;
    logic [TOT_W-1:0]  delete_total;
    logic [TOT_W-1:0]  insert_total;
    logic [SIM_W-1:0]  similarity_q8;
    logic              final_record;
  } out_t;

endpackage

// ===== rtl/core/bdrc_if.sv =====
`timescale 1ns / 1ps

interface bdrc_in_if;
  logic           valid;
  logic           ready;
  bdrc_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdrc_out_if;
  logic           valid;
  logic           ready;
  bdrc_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/byte_diff_run_classifier.sv =====
// a byte pair without end passes the close and entry states, then its entry word is registered on the output
// the input is ready only in the idle state, so no new item is taken before the last one is through
// an end item flushes the open run and computes the similarity with the 15-step restoring divider
// an item with neither byte and no end passes the close and entry states and returns to ready
// reset (asynchronous, active low) clears the counters, the open run and the output valid
`timescale 1ns / 1ps

module byte_diff_run_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  bdrc_in_if.sink            in_i,
  bdrc_out_if.source         out_o
);

  bdrc_pkg::state_e                state_q, state_d;

  logic [bdrc_pkg::CNT_W-1:0]      pos_q, pos_d;
  logic [bdrc_pkg::CNT_W-1:0]      match_q, match_d;
  logic [bdrc_pkg::CNT_W-1:0]      mism_q, mism_d;
  logic [bdrc_pkg::CNT_W-1:0]      del_q, del_d;
  logic [bdrc_pkg::CNT_W-1:0]      ins_q, ins_d;
  logic                            run_open_q, run_open_d;
  bdrc_pkg::kind_e                 run_kind_q, run_kind_d;
  logic [bdrc_pkg::POS_W-1:0]      run_start_q, run_start_d;
  logic [bdrc_pkg::LEN_W-1:0]      run_len_q, run_len_d;

  bdrc_pkg::kind_e                 it_kind_q, it_kind_d;
  logic [7:0]                      it_a_q, it_a_d;
  logic [7:0]                      it_b_q, it_b_d;
  logic                            it_act_q, it_act_d;
  logic                            it_end_q, it_end_d;
  logic [bdrc_pkg::SIM_W-1:0]      sim_q, sim_d;

  logic                            out_valid_q, out_valid_d;
  bdrc_pkg::out_t                  out_q, rec_d;
  logic                            emit;
  logic                            emit_ok;
  logic                            accept;

  logic                            div_start;
  logic [bdrc_pkg::NUM_W-1:0]      div_num;
  logic                            div_done;
  logic [bdrc_pkg::SIM_W-1:0]      div_quot;
  bdrc_pkg::out_t                  blk;
  bdrc_pkg::kind_e                 in_kind;

  assign accept  = in_i.valid && in_i.ready;
  assign emit_ok = !out_valid_q || out_o.ready;
  assign div_num = bdrc_pkg::NUM_W'(match_q) * bdrc_pkg::NUM_W'(bdrc_pkg::SIM_FULL);

  bdrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (pos_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (in_i.data.has_a && in_i.data.has_b) begin
      in_kind = (in_i.data.byte_a == in_i.data.byte_b) ? bdrc_pkg::KIND_MATCH
                                                       : bdrc_pkg::KIND_MISMATCH;
    end else if (in_i.data.has_a) begin
      in_kind = bdrc_pkg::KIND_DELETE;
    end else begin
      in_kind = bdrc_pkg::KIND_INSERT;
    end
  end

  always_comb begin
    blk             = '0;
    blk.record_type = bdrc_pkg::REC_BLOCK;
    blk.position    = run_start_q;
    blk.run_length  = run_len_q;
    blk.diff_kind   = run_kind_q;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    match_d     = match_q;
    mism_d      = mism_q;
    del_d       = del_q;
    ins_d       = ins_q;
    run_open_d  = run_open_q;
    run_kind_d  = run_kind_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    it_kind_d   = it_kind_q;
    it_a_d      = it_a_q;
    it_b_d      = it_b_q;
    it_act_d    = it_act_q;
    it_end_d    = it_end_q;
    sim_d       = sim_q;
    rec_d       = '0;
    emit        = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      bdrc_pkg::ST_IDLE: begin
        if (accept) begin
          it_kind_d = in_kind;
          it_a_d    = in_i.data.has_a ? in_i.data.byte_a : 8'd0;
          it_b_d    = in_i.data.has_b ? in_i.data.byte_b : 8'd0;
          it_act_d  = (in_i.data.has_a || in_i.data.has_b) && !pos_q[bdrc_pkg::OFFSET_BITS];
          it_end_d  = in_i.data.end_of_compare;
          state_d   = bdrc_pkg::ST_CLOSE;
        end
      end

      bdrc_pkg::ST_CLOSE: begin
        if (it_act_q && run_open_q && run_kind_q != it_kind_q
            && run_kind_q != bdrc_pkg::KIND_MATCH) begin
          if (emit_ok) begin
            emit    = 1'b1;
            rec_d   = blk;
            state_d = bdrc_pkg::ST_ENTRY;
          end
        end else begin
          state_d = bdrc_pkg::ST_ENTRY;
        end
      end

      bdrc_pkg::ST_ENTRY: begin
        if (!it_act_q || emit_ok) begin
          state_d = it_end_q ? bdrc_pkg::ST_FLUSH : bdrc_pkg::ST_IDLE;
        end
        if (it_act_q && emit_ok) begin
          emit               = 1'b1;
          rec_d.record_type  = bdrc_pkg::REC_ENTRY;
          rec_d.position     = bdrc_pkg::POS_W'(pos_q);
          rec_d.diff_kind    = it_kind_q;
          rec_d.out_byte_a   = it_a_q;
          rec_d.out_byte_b   = it_b_q;
          rec_d.final_record = !it_end_q;
          case (it_kind_q)
            bdrc_pkg::KIND_MATCH:    match_d = match_q + bdrc_pkg::CNT_W'(1);
            bdrc_pkg::KIND_MISMATCH: mism_d  = mism_q + bdrc_pkg::CNT_W'(1);
            bdrc_pkg::KIND_DELETE:   del_d   = del_q + bdrc_pkg::CNT_W'(1);
            default:                 ins_d   = ins_q + bdrc_pkg::CNT_W'(1);
          endcase
          if (run_open_q && run_kind_q == it_kind_q) begin
            run_len_d = run_len_q + bdrc_pkg::LEN_W'(1);
          end else begin
            run_open_d  = 1'b1;
            run_kind_d  = it_kind_q;
            run_start_d = bdrc_pkg::POS_W'(pos_q);
            run_len_d   = bdrc_pkg::LEN_W'(1);
          end
          pos_d = pos_q + bdrc_pkg::CNT_W'(1);
        end
      end

      bdrc_pkg::ST_FLUSH: begin
        if (run_open_q && run_kind_q != bdrc_pkg::KIND_MATCH) begin
          if (emit_ok) begin
            emit    = 1'b1;
            rec_d   = blk;
            state_d = bdrc_pkg::ST_DIV_START;
          end
        end else begin
          state_d = bdrc_pkg::ST_DIV_START;
        end
      end

      bdrc_pkg::ST_DIV_START: begin
        if (pos_q == '0) begin
          sim_d   = bdrc_pkg::SIM_FULL;
          state_d = bdrc_pkg::ST_SUM;
        end else begin
          div_start = 1'b1;
          state_d   = bdrc_pkg::ST_DIV;
        end
      end

      bdrc_pkg::ST_DIV: begin
        if (div_done) begin
          sim_d   = div_quot;
          state_d = bdrc_pkg::ST_SUM;
        end
      end

      bdrc_pkg::ST_SUM: begin
        if (emit_ok) begin
          emit                 = 1'b1;
          rec_d.record_type    = bdrc_pkg::REC_SUMMARY;
          rec_d.match_total    = bdrc_pkg::TOT_W'(match_q);
          rec_d.mismatch_total = bdrc_pkg::TOT_W'(mism_q);
          rec_d.delete_total   = bdrc_pkg::TOT_W'(del_q);
          rec_d.insert_total   = bdrc_pkg::TOT_W'(ins_q);
          rec_d.similarity_q8  = sim_q;
          rec_d.final_record   = 1'b1;
          pos_d                = '0;
          match_d              = '0;
          mism_d               = '0;
          del_d                = '0;
          ins_d                = '0;
          run_open_d           = 1'b0;
          run_kind_d           = bdrc_pkg::KIND_MATCH;
          run_start_d          = '0;
          run_len_d            = '0;
          state_d              = bdrc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bdrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdrc_pkg::ST_IDLE;
      pos_q       <= '0;
      match_q     <= '0;
      mism_q      <= '0;
      del_q       <= '0;
      ins_q       <= '0;
      run_open_q  <= 1'b0;
      run_kind_q  <= bdrc_pkg::KIND_MATCH;
      run_start_q <= '0;
      run_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      match_q     <= match_d;
      mism_q      <= mism_d;
      del_q       <= del_d;
      ins_q       <= ins_d;
      run_open_q  <= run_open_d;
      run_kind_q  <= run_kind_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_kind_q <= it_kind_d;
    it_a_q    <= it_a_d;
    it_b_q    <= it_b_d;
    it_act_q  <= it_act_d;
    it_end_q  <= it_end_d;
    sim_q     <= sim_d;
    if (emit) begin
      out_q <= rec_d;
    end
  end

  assign in_i.ready  = (state_q == bdrc_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_summary_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.record_type == bdrc_pkg::REC_SUMMARY |-> out_q.final_record)
    else $error("summary word without final flag");

  a_block_not_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.record_type == bdrc_pkg::REC_BLOCK
    |-> out_q.diff_kind != bdrc_pkg::KIND_MATCH && !out_q.final_record)
    else $error("block word with match kind or final flag");

  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bdrc_pkg::CNT_W+2)'(match_q) + (bdrc_pkg::CNT_W+2)'(mism_q)
    + (bdrc_pkg::CNT_W+2)'(del_q) + (bdrc_pkg::CNT_W+2)'(ins_q)
    == (bdrc_pkg::CNT_W+2)'(pos_q))
    else $error("class counts do not add up to position count");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bdrc_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_run_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> run_len_q != '0)
    else $error("open run with zero length");
`endif

endmodule

// ===== rtl/core/bdrc_div.sv =====
`timescale 1ns / 1ps

module bdrc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bdrc_pkg::NUM_W-1:0]     num_i,
  input  logic [bdrc_pkg::CNT_W-1:0]     den_i,
  output logic                           done_o,
  output logic [bdrc_pkg::SIM_W-1:0]     quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [bdrc_pkg::STEP_W-1:0]     step_q, step_d;
  logic [bdrc_pkg::NUM_W-1:0]      rem_q, rem_d;
  logic [bdrc_pkg::NUM_W-2:0]      dsh_q, dsh_d;
  logic [bdrc_pkg::SIM_W-1:0]      quot_q, quot_d;
  logic                            ge;
  logic [bdrc_pkg::NUM_W-1:0]      diff;

  // one restoring step per cycle, divisor pre-shifted to the top quotient bit
  assign ge   = rem_q >= bdrc_pkg::NUM_W'(dsh_q);
  assign diff = rem_q - bdrc_pkg::NUM_W'(dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = num_i;
      dsh_d  = {den_i, {(bdrc_pkg::SIM_W-1){1'b0}}};
    end else if (busy_q) begin
      if (ge) begin
        rem_d = diff;
      end
      quot_d = {quot_q[bdrc_pkg::SIM_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      if (step_q == bdrc_pkg::STEP_W'(bdrc_pkg::SIM_W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + bdrc_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== verif/tb_byte_diff_run_classifier.sv =====
`timescale 1ns / 1ps

module tb_byte_diff_run_classifier;

  typedef struct {
    bdrc_pkg::in_t word;
    bit            drain;
  } pending_t;

  typedef enum {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE
  } stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdrc_in_if  in_if ();
  bdrc_out_if out_if ();

  byte_diff_run_classifier u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  pending_t       pending_q[$];
  bdrc_pkg::out_t expected_q[$];
  bdrc_pkg::out_t want_word;
  int             errors;
  int             words_outstanding;
  int             words_checked;
  int             live_items;
  bit             drain_next;

  int burst_left;
  int gap_left;

  int          hold_left;
  int          mode_cycles;
  bit          long_hold_done;
  stall_mode_e rdy_mode;

  // comparison state of the predictor
  logic [bdrc_pkg::CNT_W-1:0] pos_cnt;
  bdrc_pkg::kind_e            run_kind;
  logic [bdrc_pkg::POS_W-1:0] run_start;
  logic [bdrc_pkg::LEN_W-1:0] run_len;
  bit                         run_open;
  logic [bdrc_pkg::TOT_W-1:0] match_cnt;
  logic [bdrc_pkg::TOT_W-1:0] mismatch_cnt;
  logic [bdrc_pkg::TOT_W-1:0] delete_cnt;
  logic [bdrc_pkg::TOT_W-1:0] insert_cnt;

  task automatic clear_tally();
    pos_cnt      = '0;
    run_kind     = bdrc_pkg::KIND_MATCH;
    run_start    = '0;
    run_len      = '0;
    run_open     = 1'b0;
    match_cnt    = '0;
    mismatch_cnt = '0;
    delete_cnt   = '0;
    insert_cnt   = '0;
  endtask

  function automatic bdrc_pkg::out_t run_block();
    bdrc_pkg::out_t rec;
    rec             = '0;
    rec.record_type = bdrc_pkg::REC_BLOCK;
    rec.position    = run_start;
    rec.run_length  = run_len;
    rec.diff_kind   = run_kind;
    return rec;
  endfunction

  task automatic predict_words(input bdrc_pkg::in_t w);
    bdrc_pkg::out_t  recs[4];
    int              n;
    bdrc_pkg::kind_e k;
    logic [7:0]      a;
    logic [7:0]      b;
    logic [63:0]     sim;
    n = 0;
    a = w.byte_a;
    b = w.byte_b;
    if ((w.has_a || w.has_b) &&
        pos_cnt < (bdrc_pkg::CNT_W'(1) << bdrc_pkg::OFFSET_BITS)) begin
      if (w.has_a && w.has_b) begin
        k = (a == b) ? bdrc_pkg::KIND_MATCH : bdrc_pkg::KIND_MISMATCH;
      end else if (w.has_a) begin
        k = bdrc_pkg::KIND_DELETE;
        b = '0;
      end else begin
        k = bdrc_pkg::KIND_INSERT;
        a = '0;
      end
      case (k)
        bdrc_pkg::KIND_MATCH:    match_cnt++;
        bdrc_pkg::KIND_MISMATCH: mismatch_cnt++;
        bdrc_pkg::KIND_DELETE:   delete_cnt++;
        default:                 insert_cnt++;
      endcase
      if (run_open && run_kind == k) begin
        run_len++;
      end else begin
        if (run_open && run_kind != bdrc_pkg::KIND_MATCH) begin
          recs[n] = run_block();
          n++;
        end
        run_open  = 1'b1;
        run_kind  = k;
        run_start = pos_cnt[bdrc_pkg::POS_W-1:0];
        run_len   = bdrc_pkg::LEN_W'(1);
      end
      recs[n]             = '0;
      recs[n].record_type = bdrc_pkg::REC_ENTRY;
      recs[n].position    = pos_cnt[bdrc_pkg::POS_W-1:0];
      recs[n].diff_kind   = k;
      recs[n].out_byte_a  = a;
      recs[n].out_byte_b  = b;
      n++;
      pos_cnt++;
    end
    if (w.end_of_compare) begin
      if (run_open && run_kind != bdrc_pkg::KIND_MATCH) begin
        recs[n] = run_block();
        n++;
      end
      if (pos_cnt == '0) begin
        sim = 64'(bdrc_pkg::SIM_FULL);
      end else begin
        sim = (64'(match_cnt) * 64'(bdrc_pkg::SIM_FULL)) / 64'(pos_cnt);
      end
      recs[n]                = '0;
      recs[n].record_type    = bdrc_pkg::REC_SUMMARY;
      recs[n].match_total    = match_cnt;
      recs[n].mismatch_total = mismatch_cnt;
      recs[n].delete_total   = delete_cnt;
      recs[n].insert_total   = insert_cnt;
      recs[n].similarity_q8  = sim[bdrc_pkg::SIM_W-1:0];
      n++;
      clear_tally();
    end
    if (n > 0) begin
      recs[n-1].final_record = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_q.push_back(recs[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic add_item(input logic [7:0] a, input bit ha, input logic [7:0] b,
                          input bit hb, input bit e);
    pending_t p;
    p.word.byte_a         = a;
    p.word.has_a          = ha;
    p.word.byte_b         = b;
    p.word.has_b          = hb;
    p.word.end_of_compare = e;
    p.drain               = drain_next;
    drain_next            = 1'b0;
    pending_q.push_back(p);
    if (ha || hb || e) begin
      live_items++;
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      burst_left  = 4;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        void'(pending_q.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          gap_left   = $urandom_range(0, 6);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
        end
      end
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain || (!in_if.valid && words_outstanding == 0))) begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_q[0].word;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready   <= 1'b0;
      hold_left      = 0;
      mode_cycles    = 0;
      long_hold_done = 1'b0;
      rdy_mode       = RDY_ALWAYS;
    end else begin
      mode_cycles++;
      if (mode_cycles == 64) begin
        mode_cycles = 0;
        rdy_mode    = stall_mode_e'($urandom_range(0, 2));
      end
      if (!long_hold_done && words_checked >= 80) begin
        long_hold_done = 1'b1;
        hold_left      = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rdy_mode)
          RDY_ALWAYS: out_if.ready <= 1'b1;
          RDY_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          default:    out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: checks output words, then predicts from accepted input words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tally();
      expected_q.delete();
      words_outstanding <= 0;
      words_checked     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_checked <= words_checked + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected output word: record_type %0d position %0d",
                 out_if.data.record_type, out_if.data.position);
          errors++;
        end else begin
          want_word = expected_q.pop_front();
          check_field("record_type", 64'(want_word.record_type),
                      64'(out_if.data.record_type));
          check_field("position", 64'(want_word.position), 64'(out_if.data.position));
          check_field("run_length", 64'(want_word.run_length),
                      64'(out_if.data.run_length));
          check_field("diff_kind", 64'(want_word.diff_kind), 64'(out_if.data.diff_kind));
          check_field("out_byte_a", 64'(want_word.out_byte_a),
                      64'(out_if.data.out_byte_a));
          check_field("out_byte_b", 64'(want_word.out_byte_b),
                      64'(out_if.data.out_byte_b));
          check_field("match_total", 64'(want_word.match_total),
                      64'(out_if.data.match_total));
          check_field("mismatch_total", 64'(want_word.mismatch_total),
                      64'(out_if.data.mismatch_total));
          check_field("delete_total", 64'(want_word.delete_total),
                      64'(out_if.data.delete_total));
          check_field("insert_total", 64'(want_word.insert_total),
                      64'(out_if.data.insert_total));
          check_field("similarity_q8", 64'(want_word.similarity_q8),
                      64'(out_if.data.similarity_q8));
          check_field("final_record", 64'(want_word.final_record),
                      64'(out_if.data.final_record));
        end
      end
      if (in_if.valid && in_if.ready) begin
        predict_words(in_if.data);
      end
      words_outstanding <= expected_q.size();
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          span;
    int          la;
    int          lb;
    int          p_match;
    bit          ha;
    bit          hb;
    bit          end_on_last;
    logic [7:0]  a;
    logic [7:0]  b;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    rst_ni       = 1'b0;
    errors       = 0;
    live_items   = 0;
    drain_next   = 1'b0;

    // end on an empty comparison, then an ignored item
    add_item(8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b0, 8'hff, 1'b0, 1'b0);
    // matches, mismatches, deletes, then inserts ending on a byte
    add_item(8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 8'hff, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 8'hff, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 8'h00, 1'b1, 1'b0);
    add_item(8'h55, 1'b1, 8'haa, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 8'h3c, 1'b0, 1'b0);
    add_item(8'h01, 1'b1, 8'hc3, 1'b0, 1'b0);
    add_item(8'hab, 1'b0, 8'hff, 1'b1, 1'b0);
    add_item(8'h7e, 1'b0, 8'h80, 1'b1, 1'b1);
    // common position after a tail position
    add_item(8'h12, 1'b1, 8'h00, 1'b0, 1'b0);
    add_item(8'h34, 1'b1, 8'h34, 1'b1, 1'b1);
    // close, entry, flush and summary from one word
    add_item(8'h10, 1'b1, 8'h20, 1'b1, 1'b0);
    add_item(8'h30, 1'b1, 8'h40, 1'b1, 1'b0);
    add_item(8'h99, 1'b1, 8'h00, 1'b0, 1'b1);
    // all matches, separate end
    add_item(8'h5a, 1'b1, 8'h5a, 1'b1, 1'b0);
    add_item(8'ha5, 1'b1, 8'ha5, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    // one third similarity, insert, match, then mismatch
    add_item(8'h66, 1'b0, 8'h77, 1'b1, 1'b0);
    add_item(8'h88, 1'b1, 8'h88, 1'b1, 1'b0);
    add_item(8'h88, 1'b1, 8'h89, 1'b1, 1'b1);

    drain_next = 1'b1;
    while (live_items < 145) begin
      if (live_items > 110 && live_items < 115) begin
        drain_next = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise in tail order
        repeat ($urandom_range(1, 6)) begin
          add_item(8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                   ($urandom_range(0, 5) == 0));
        end
      end else begin
        la = $urandom_range(0, 10);
        lb = ($urandom_range(0, 2) == 0) ? la : $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) begin
          la = 40;
          lb = $urandom_range(30, 40);
        end
        p_match     = $urandom_range(0, 4);
        span        = (la > lb) ? la : lb;
        end_on_last = 1'($urandom);
        for (int i = 0; i < span; i++) begin
          if ($urandom_range(0, 12) == 0) begin
            add_item(8'($urandom), 1'b0, 8'($urandom), 1'b0, 1'b0);
          end
          ha = (i < la);
          hb = (i < lb);
          a  = 8'($urandom);
          b  = (ha && hb && $urandom_range(1, 4) <= p_match) ? a : 8'($urandom);
          add_item(a, ha, b, hb, end_on_last && (i == span - 1));
        end
        if (span == 0 || !end_on_last) begin
          add_item(8'($urandom), 1'b0, 8'($urandom), 1'b0, 1'b1);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_if.valid || words_outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (40) @(negedge clk_i);
    if (errors == 0 && words_outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
